/* rtl/core/wad_pkg.sv */
// wad_pkg: shared types and constants for the window average/dispersion block.
// No dependencies.
`default_nettype none
package wad_pkg;
	localparam int unsigned SPREAD_SENTINEL  = 1000;
	localparam int unsigned SPREAD_MIN_COUNT = 3;
	localparam int unsigned CFG_BITS         = 6;
	localparam int unsigned SPREAD_BITS      = 24;
	localparam int unsigned MEAN_BITS        = 12;
endpackage
`default_nettype wire

/* rtl/core/wad_cell.sv */
// wad_cell: one window slot of the circulating sample chain.
// Depends on nothing; used by window_average_dispersion.
`default_nettype none
module wad_cell #(
	parameter int unsigned W = 12
) (
	input  wire logic         clk,
	input  wire logic         load,
	input  wire logic         shift,
	input  wire logic [W-1:0] load_data,
	input  wire logic [W-1:0] prev_data,
	output logic      [W-1:0] data
);
	logic [W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else if (shift) begin
			data_q <= prev_data;
		end
	end

	assign data = data_q;
endmodule
`default_nettype wire

/* rtl/core/wad_div.sv */
// wad_div: restoring divider, one quotient bit a cycle.
// Depends on nothing; used by window_average_dispersion.
`default_nettype none
module wad_div #(
	parameter int unsigned NW = 40,
	parameter int unsigned DW = 9
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic      [NW-1:0] quo
);
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic [DW+1:0] diff;

	assign trial = {rem_q[DW-1:0], quo_q[NW-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DW+1]) begin
				rem_q <= diff[DW:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
endmodule
`default_nettype wire

/* rtl/core/window_average_dispersion.sv */
// window_average_dispersion: top level of the sliding-window mean and dispersion.
// Depends on wad_pkg, wad_cell, wad_div.
//
// Each sample beat is written into a row of MAX_DEPTH cells; the row holds the
// window in store order. For every sample the row circulates twice, one cell
// per cycle past a single accumulator: first summing for the mean, then summing
// squared deviations. Each sum is divided by the fill count in a bit-serial
// divider. The work of an item is the two row walks and the two divisions;
// with fewer than three held samples the second division is skipped. One item
// is in flight at a time; the result sits in an output register and the next
// sample is taken once it is drained. A write on the configuration port
// empties the window.
`default_nettype none
module window_average_dispersion #(
	parameter int unsigned MAX_DEPTH   = 32,
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [5:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [11:0] sample,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [11:0]      mean_value,
	output logic [23:0]      spread,
	output logic             spread_valid
);
	localparam int unsigned PW       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int unsigned NW       = $clog2(MAX_DEPTH + 1);
	localparam int unsigned SQ_BITS  = 2 * SAMPLE_BITS;
	localparam int unsigned SUM_BITS = SQ_BITS + NW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_MDIV = 3'd2;
	localparam logic [2:0] ST_SQ   = 3'd3;
	localparam logic [2:0] ST_SDIV = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]    state_q;
	logic [5:0]    wlen_q;
	logic [NW-1:0] fill_q;
	logic [PW-1:0] wpos_q;
	logic [NW-1:0] len;
	logic [NW-1:0] step_q;
	logic [SUM_BITS-1:0] acc_q;
	logic [SAMPLE_BITS-1:0] mean_q;
	logic [SQ_BITS-1:0] sq_s1;
	logic          sq_v_s1;

	// row of cells: circulation shifts toward cell 0, cell MAX_DEPTH-1 takes cell 0
	logic [SAMPLE_BITS-1:0] cell_data [MAX_DEPTH];
	logic [SAMPLE_BITS-1:0] smp;
	logic          walking;
	logic [PW-1:0] load_idx;
	logic          load_en;

	assign smp = sample[SAMPLE_BITS-1:0];

	always_comb begin
		len = NW'(wlen_q);
		if (wlen_q == 6'd0) len = NW'(1);
		if ({26'd0, wlen_q} > 32'(MAX_DEPTH)) len = NW'(MAX_DEPTH);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !in_valid;
	assign load_en   = in_valid && in_ready;
	assign walking   = (state_q == ST_SUM || state_q == ST_SQ) && (step_q != '0);

	always_comb begin
		if (fill_q < len) load_idx = PW'(fill_q);
		else if ({{(NW-PW){1'b0}}, wpos_q} >= len) load_idx = '0;
		else load_idx = wpos_q;
	end

	for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
		wad_cell #(.W(SAMPLE_BITS)) u_cell (
			.clk      (clk),
			.load     (load_en && (load_idx == PW'(g))),
			.shift    (walking),
			.load_data(smp),
			.prev_data(cell_data[(g + 1) % MAX_DEPTH]),
			.data     (cell_data[g])
		);
	end

	// cell 0 streams past; only the first fill_q beats of a full lap count
	logic [NW-1:0] lap_q;
	logic          head_live;
	logic [SAMPLE_BITS-1:0] dev;
	assign head_live = (lap_q < fill_q);
	assign dev = (cell_data[0] >= mean_q) ? cell_data[0] - mean_q : mean_q - cell_data[0];

	logic          div_start, div_done;
	logic [SUM_BITS-1:0] div_num, div_quo;
	wad_div #(.NW(SUM_BITS), .DW(NW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (fill_q),
		.done  (div_done),
		.quo   (div_quo)
	);
	assign div_num = acc_q + SUM_BITS'(fill_q >> 1);

	always_ff @(posedge clk) begin
		sq_s1 <= SQ_BITS'(dev) * SQ_BITS'(dev);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wlen_q    <= 6'd32;
			fill_q    <= '0;
			wpos_q    <= '0;
			step_q    <= '0;
			lap_q     <= '0;
			sq_v_s1   <= 1'b0;
			div_start <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			div_start <= 1'b0;
			sq_v_s1   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						wlen_q <= cfg_data;
						fill_q <= '0;
						wpos_q <= '0;
					end else if (load_en) begin
						if (fill_q < len) begin
							fill_q <= fill_q + 1'b1;
						end else if (NW'(load_idx) + 1'b1 >= len) begin
							wpos_q <= '0;
						end else begin
							wpos_q <= load_idx + 1'b1;
						end
						step_q  <= NW'(MAX_DEPTH);
						lap_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (step_q != '0) begin
						step_q <= step_q - 1'b1;
						lap_q  <= lap_q + 1'b1;
					end else begin
						div_start <= 1'b1;
						state_q   <= ST_MDIV;
					end
				end
				ST_MDIV: begin
					if (div_done) begin
						step_q  <= NW'(MAX_DEPTH);
						lap_q   <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (step_q != '0) begin
						step_q  <= step_q - 1'b1;
						lap_q   <= lap_q + 1'b1;
						sq_v_s1 <= head_live;
					end else if (!sq_v_s1) begin
						if (fill_q >= NW'(wad_pkg::SPREAD_MIN_COUNT)) begin
							div_start <= 1'b1;
							state_q   <= ST_SDIV;
						end else begin
							out_valid <= 1'b1;
							state_q   <= ST_OUT;
						end
					end
				end
				ST_SDIV: begin
					if (div_done) begin
						out_valid <= 1'b1;
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// accumulator and result registers
	always_ff @(posedge clk) begin
		if (load_en) begin
			acc_q <= '0;
		end else if (state_q == ST_SUM && step_q != '0 && head_live) begin
			acc_q <= acc_q + SUM_BITS'(cell_data[0]);
		end else if (state_q == ST_MDIV && div_done) begin
			acc_q  <= '0;
			mean_q <= div_quo[SAMPLE_BITS-1:0];
		end else if (sq_v_s1) begin
			acc_q <= acc_q + SUM_BITS'(sq_s1);
		end
		if (state_q == ST_SQ && step_q == '0 && !sq_v_s1) begin
			spread       <= 24'(wad_pkg::SPREAD_SENTINEL);
			spread_valid <= 1'b0;
		end
		if (state_q == ST_SDIV && div_done) begin
			spread       <= (div_quo > SUM_BITS'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(div_quo);
			spread_valid <= 1'b1;
		end
	end

	assign mean_value = 12'(mean_q);
endmodule
`default_nettype wire
